/* rtl/byte_ring_fifo_with_search_defines.svh */
// ----------------------------------------------------------------------------
// byte ring fifo with search: assertion macros
// shared property wrappers for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_SEARCH_DEFINES_SVH

// same-cycle implication
`define BRFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/brfs_pkg.sv */
// ----------------------------------------------------------------------------
// brfs_pkg
// types and fixed constants of the byte ring fifo with search
// ----------------------------------------------------------------------------
package brfs_pkg;

    localparam int CAP_W  = 7;
    localparam int FILL_W = 6;

    localparam logic [CAP_W-1:0] CAP_MIN = 7'd2;

    localparam logic [2:0] CMD_ENQ      = 3'd0;
    localparam logic [2:0] CMD_DEQ      = 3'd1;
    localparam logic [2:0] CMD_CLEAR    = 3'd2;
    localparam logic [2:0] CMD_FIND     = 3'd3;
    localparam logic [2:0] CMD_FINDLINE = 3'd4;
    localparam logic [2:0] CMD_PEEK     = 3'd5;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_in;
        logic [5:0] offset;
    } t_cmd_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] data_out;
        logic [5:0] position;
        logic [5:0] fill;
        logic       full_res;
        logic       empty_res;
    } t_res_item;

endpackage

/* rtl/brfs_mem.sv */
// ----------------------------------------------------------------------------
// brfs_mem
// byte storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module brfs_mem #(
    parameter int DEPTH = 64,
    parameter int PW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [PW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [PW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/brfs_unit.sv */
// ----------------------------------------------------------------------------
// brfs_unit
// shared step unit: modular pointer add against capacity, byte match
// ----------------------------------------------------------------------------
module brfs_unit #(
    parameter int PW = 6,
    parameter int WW = 8
) (
    input  logic [PW-1:0]              i_a,
    input  logic [WW-1:0]              i_b,
    input  logic [brfs_pkg::CAP_W-1:0] i_cap,
    input  logic [7:0]                 i_byte,
    input  logic [7:0]                 i_target,
    input  logic                       i_line_mode,
    output logic [PW-1:0]              o_sum,
    output logic                       o_hit
);

    logic [WW-1:0] sum_raw;
    logic [WW-1:0] cap_x;
    logic [WW-1:0] sum_wrap;

    assign cap_x   = WW'(i_cap);
    assign sum_raw = WW'(i_a) + i_b;

    always_comb begin
        if (sum_raw >= cap_x) begin
            sum_wrap = sum_raw - cap_x;
        end else begin
            sum_wrap = sum_raw;
        end
    end

    assign o_sum = sum_wrap[PW-1:0];

    always_comb begin
        if (i_line_mode) begin
            o_hit = (i_byte == brfs_pkg::CR_BYTE) || (i_byte == brfs_pkg::LF_BYTE);
        end else begin
            o_hit = (i_byte == i_target);
        end
    end

endmodule

/* rtl/byte_ring_fifo_with_search.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search
// byte ring fifo with runtime capacity, find, find line end and peek
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; each gives one result
// item, shown for exactly one cycle with o_done, and it cannot be held off.
// Enqueue, clear and unknown codes go straight to the finish state; dequeue
// and peek pass through a read state first (one registered storage read),
// but skip it when the ring is empty or the offset is out of range. Find and
// find line end read the single storage port one slot per cycle from the
// head until a match or the write pointer is reached. Writing capacity
// empties the ring; it takes effect at once.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  brfs_pkg::t_cmd_item        i_cmd_item,
    output logic                       o_done,
    output brfs_pkg::t_res_item        o_res_item,
    input  logic                       i_cfg_we,
    input  logic [brfs_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int PW  = $clog2(DEPTH);
    localparam int WW  = ((PW > brfs_pkg::CAP_W) ? PW : brfs_pkg::CAP_W) + 1;
    localparam int CAP_MAX_I = (DEPTH > 127) ? 127 : DEPTH;
    localparam int CAP_RST_I = (DEPTH > 64) ? 64 : DEPTH;
    localparam logic [brfs_pkg::CAP_W-1:0] CAP_MAX = brfs_pkg::CAP_W'(CAP_MAX_I);
    localparam logic [brfs_pkg::CAP_W-1:0] CAP_RST = brfs_pkg::CAP_W'(CAP_RST_I);

    brfs_pkg::t_state r_state, n_state;

    logic [PW-1:0]              r_wp, n_wp;
    logic [PW-1:0]              r_rp, n_rp;
    logic [brfs_pkg::CAP_W-1:0] r_cap, n_cap;
    logic [2:0]                 r_cmd, n_cmd;
    logic                       r_mode, n_mode;
    logic [7:0]                 r_target, n_target;
    logic [PW-1:0]              r_ptr, n_ptr;
    logic [brfs_pkg::CAP_W-1:0] r_k, n_k;
    logic [brfs_pkg::CAP_W-1:0] r_kpend, n_kpend;
    logic                       r_pend, n_pend;
    logic                       r_ok, n_ok;
    logic [7:0]                 r_dout, n_dout;
    logic [5:0]                 r_pos, n_pos;
    brfs_pkg::t_res_item        r_res, n_res;
    logic                       r_done, n_done;

    logic          accept;
    logic [WW-1:0] wp_x, rp_x, cap_x, fill_w;
    logic          full_w, empty_w, off_ok;
    logic          mem_we;
    logic [PW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic [PW-1:0] u_a, u_sum;
    logic [WW-1:0] u_b;
    logic          u_hit;
    logic [brfs_pkg::CAP_W-1:0] cap_clamp;

    assign busy   = (r_state != brfs_pkg::S_IDLE);
    assign accept = start && !busy;

    // occupancy from the pointers
    assign wp_x  = WW'(r_wp);
    assign rp_x  = WW'(r_rp);
    assign cap_x = WW'(r_cap);

    always_comb begin
        if (wp_x >= rp_x) begin
            fill_w = wp_x - rp_x;
        end else begin
            fill_w = wp_x + cap_x - rp_x;
        end
    end

    assign full_w  = (WW'(fill_w + WW'(1)) == cap_x);
    assign empty_w = (r_wp == r_rp);
    assign off_ok  = (WW'(i_cmd_item.offset) < fill_w);

    always_comb begin
        if (i_cfg_data < brfs_pkg::CAP_MIN) begin
            cap_clamp = brfs_pkg::CAP_MIN;
        end else if (i_cfg_data > CAP_MAX) begin
            cap_clamp = CAP_MAX;
        end else begin
            cap_clamp = i_cfg_data;
        end
    end

    brfs_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd_item.data_in),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    brfs_unit #(
        .PW (PW),
        .WW (WW)
    ) u_unit (
        .i_a         (u_a),
        .i_b         (u_b),
        .i_cap       (r_cap),
        .i_byte      (mem_rdata),
        .i_target    (r_target),
        .i_line_mode (r_mode),
        .o_sum       (u_sum),
        .o_hit       (u_hit)
    );

    // shared unit operand select
    always_comb begin
        u_a = r_rp;
        u_b = WW'(1);
        unique case (r_state)
            brfs_pkg::S_IDLE: begin
                if (i_cmd_item.cmd == brfs_pkg::CMD_ENQ) begin
                    u_a = r_wp;
                end else if (i_cmd_item.cmd == brfs_pkg::CMD_PEEK) begin
                    u_b = WW'(i_cmd_item.offset);
                end
            end
            brfs_pkg::S_SCAN: begin
                u_a = r_ptr;
            end
            default: begin
                u_a = r_rp;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brfs_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd_item.cmd)
                        brfs_pkg::CMD_DEQ:      n_state = empty_w ? brfs_pkg::S_FIN
                                                                  : brfs_pkg::S_READ;
                        brfs_pkg::CMD_PEEK:     n_state = off_ok ? brfs_pkg::S_READ
                                                                 : brfs_pkg::S_FIN;
                        brfs_pkg::CMD_FIND:     n_state = brfs_pkg::S_SCAN;
                        brfs_pkg::CMD_FINDLINE: n_state = brfs_pkg::S_SCAN;
                        default:                n_state = brfs_pkg::S_FIN;
                    endcase
                end
            end
            brfs_pkg::S_READ: begin
                n_state = brfs_pkg::S_FIN;
            end
            brfs_pkg::S_SCAN: begin
                if ((r_pend && u_hit) || (r_ptr == r_wp)) begin
                    n_state = brfs_pkg::S_FIN;
                end
            end
            brfs_pkg::S_FIN: begin
                n_state = brfs_pkg::S_IDLE;
            end
            default: begin
                n_state = brfs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_cap     = r_cap;
        n_cmd     = r_cmd;
        n_mode    = r_mode;
        n_target  = r_target;
        n_ptr     = r_ptr;
        n_k       = r_k;
        n_kpend   = r_kpend;
        n_pend    = r_pend;
        n_ok      = r_ok;
        n_dout    = r_dout;
        n_pos     = r_pos;
        n_res     = r_res;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = r_rp;

        unique case (r_state)
            brfs_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_cmd_item.cmd;
                    n_ok   = 1'b0;
                    n_dout = 8'd0;
                    n_pos  = 6'd0;
                    unique case (i_cmd_item.cmd)
                        brfs_pkg::CMD_ENQ: begin
                            if (!full_w) begin
                                mem_we = 1'b1;
                                n_wp   = u_sum;
                                n_ok   = 1'b1;
                            end
                        end
                        brfs_pkg::CMD_DEQ: begin
                            n_ok = !empty_w;
                        end
                        brfs_pkg::CMD_CLEAR: begin
                            n_rp = r_wp;
                            n_ok = 1'b1;
                        end
                        brfs_pkg::CMD_FIND, brfs_pkg::CMD_FINDLINE: begin
                            n_ptr    = r_rp;
                            n_k      = '0;
                            n_pend   = 1'b0;
                            n_mode   = (i_cmd_item.cmd == brfs_pkg::CMD_FINDLINE);
                            n_target = i_cmd_item.data_in;
                        end
                        brfs_pkg::CMD_PEEK: begin
                            mem_raddr = u_sum;
                            n_ok      = off_ok;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            brfs_pkg::S_READ: begin
                n_dout = mem_rdata;
                if (r_cmd == brfs_pkg::CMD_DEQ) begin
                    n_rp = u_sum;
                end
            end
            brfs_pkg::S_SCAN: begin
                mem_raddr = r_ptr;
                if (r_pend && u_hit) begin
                    n_ok  = 1'b1;
                    n_pos = r_kpend[5:0];
                end else if (r_ptr != r_wp) begin
                    n_pend  = 1'b1;
                    n_kpend = r_k;
                    n_ptr   = u_sum;
                    n_k     = brfs_pkg::CAP_W'(r_k + brfs_pkg::CAP_W'(1));
                end
            end
            brfs_pkg::S_FIN: begin
                n_done             = 1'b1;
                n_res.ok           = r_ok;
                n_res.data_out     = r_dout;
                n_res.position     = r_pos;
                n_res.fill         = fill_w[brfs_pkg::FILL_W-1:0];
                n_res.full_res     = full_w;
                n_res.empty_res    = empty_w;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase

        if (i_cfg_we) begin
            n_cap = cap_clamp;
            n_wp  = '0;
            n_rp  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brfs_pkg::S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cap   <= CAP_RST;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cap   <= n_cap;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_mode   <= n_mode;
        r_target <= n_target;
        r_ptr    <= n_ptr;
        r_k      <= n_k;
        r_kpend  <= n_kpend;
        r_ok     <= n_ok;
        r_dout   <= n_dout;
        r_pos    <= n_pos;
        r_res    <= n_res;
    end

    assign o_done     = r_done;
    assign o_res_item = r_res;

endmodule

/* rtl/brfs_chk.sv */
// ----------------------------------------------------------------------------
// brfs_chk
// port-level checks of the byte ring fifo with search, bound to the top
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_search_defines.svh"

module brfs_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input brfs_pkg::t_res_item        o_res_item
);

    `BRFS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `BRFS_ASSERT_IMP(a_fell_done, $fell(busy), o_done, "busy dropped without a result item")
    `BRFS_ASSERT_IMP(a_empty_fill, o_done && o_res_item.empty_res, o_res_item.fill == 6'd0, "empty with nonzero fill")
    `BRFS_ASSERT_IMP(a_full_empty, o_done && o_res_item.full_res, !o_res_item.empty_res, "full and empty together")
    `BRFS_ASSERT_IMP(a_dout_ok, o_done && !o_res_item.ok, o_res_item.data_out == 8'd0, "data on failed item")

endmodule

bind byte_ring_fifo_with_search brfs_chk u_brfs_chk (.*);
